>>> design/tcw_pkg.sv
package tcw_pkg;

   localparam int SLOTS            = 4;
   localparam int ID_FIELD_BITS    = 16;
   localparam int SIZE_BITS        = 3;
   localparam int SEEN_BITS        = 4;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 16;
   localparam int QUEUE_DEPTH      = 2;

   localparam int DEFAULT_MAX_LEFT  = 4;
   localparam int DEFAULT_MAX_RIGHT = 4;
   localparam int DEFAULT_ID_BITS   = 16;

   localparam logic [SEEN_BITS-1:0]     SEEN_MAX            = 4'd15;
   localparam logic [SIZE_BITS-1:0]     LEFT_SIZE_RESET     = 3'd1;
   localparam logic [SIZE_BITS-1:0]     RIGHT_SIZE_RESET    = 3'd1;
   localparam logic [ID_FIELD_BITS-1:0] START_PAD_RESET     = 16'd0;
   localparam logic [ID_FIELD_BITS-1:0] END_PAD_RESET       = 16'd1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LEFT_SIZE  = 2'd0,
      CSR_RIGHT_SIZE = 2'd1,
      CSR_START_PAD  = 2'd2,
      CSR_END_PAD    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_SHIFT = 2'd0,
      CMD_EMIT  = 2'd1,
      CMD_FLUSH = 2'd2
   } cmd_type;

   typedef struct packed {
      cmd_type                  cmd;
      logic [SEEN_BITS-1:0]     seen;
      logic [ID_FIELD_BITS-1:0] word;
   } entry_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0]     left_size;
      logic [SIZE_BITS-1:0]     right_size;
      logic [ID_FIELD_BITS-1:0] start_pad;
      logic [ID_FIELD_BITS-1:0] end_pad;
   } cfg_type;

   typedef struct packed {
      logic [SLOTS-1:0][ID_FIELD_BITS-1:0] left;
      logic [SLOTS-1:0][ID_FIELD_BITS-1:0] right;
      logic                                final_position;
      logic                                run_last;
   } rsp_type;

endpackage

>>> design/tcw_front.sv
module tcw_front import tcw_pkg::*; #(
   parameter int WORD_BITS = DEFAULT_ID_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [ID_FIELD_BITS-1:0] req_word_id,
   input  logic                     req_sentence_end,
   input  cfg_type                  cfg,
   input  logic                     q_full,
   output logic                     q_push,
   output entry_type                q_entry
);

   logic [SEEN_BITS-1:0] seen_ff;
   logic [SEEN_BITS-1:0] seen_in;
   logic [SEEN_BITS-1:0] count;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      count = (seen_ff == SEEN_MAX) ? SEEN_MAX : seen_ff + 1'b1;
      q_entry.seen = count;
      q_entry.word = ID_FIELD_BITS'(req_word_id[WORD_BITS-1:0]);
      priority if (req_sentence_end) begin
         q_entry.cmd = CMD_FLUSH;
      end else if (count > {1'b0, cfg.right_size}) begin
         q_entry.cmd = CMD_EMIT;
      end else begin
         q_entry.cmd = CMD_SHIFT;
      end
      seen_in = seen_ff;
      if (q_push) begin
         seen_in = req_sentence_end ? '0 : count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

endmodule

>>> design/tcw_queue.sv
module tcw_queue import tcw_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   output logic      valid,
   input  logic      pop,
   output entry_type pop_entry
);

   localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0]   LAST_PTR  = PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_BITS-1:0] FULL_CNT  = COUNT_BITS'(QUEUE_DEPTH);

   entry_type             store_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff;
   logic [PTR_BITS-1:0]   wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff;
   logic [PTR_BITS-1:0]   rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;

   assign full      = (count_ff == FULL_CNT);
   assign valid     = (count_ff != '0);
   assign pop_entry = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> design/tcw_back.sv
module tcw_back import tcw_pkg::*; #(
   parameter int WIN_DEPTH = 2 * SLOTS + 1,
   parameter int WORD_BITS = DEFAULT_ID_BITS
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      q_valid,
   input  entry_type q_entry,
   output logic      q_pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   localparam int WIN_IDX_BITS = $clog2(WIN_DEPTH);
   localparam int SUM_BITS     = SIZE_BITS + 1;

   logic [WORD_BITS-1:0] window_ff [WIN_DEPTH];
   logic [WORD_BITS-1:0] window_in [WIN_DEPTH];
   logic                 busy_ff;
   logic                 busy_in;
   cmd_type              cmd_ff;
   cmd_type              cmd_in;
   logic [SIZE_BITS-1:0] d_ff;
   logic [SIZE_BITS-1:0] d_in;
   logic [SEEN_BITS-1:0] n_ff;
   logic [SEEN_BITS-1:0] n_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_type              rsp_data_ff;
   rsp_type              rsp_data_in;
   rsp_type              emit_data;

   logic                 needs_out;
   logic                 out_free;
   logic                 step;
   logic                 job_done;
   logic                 emit;
   logic [SUM_BITS-1:0]  lsum;
   logic [SUM_BITS-1:0]  rdiff;
   logic [SEEN_BITS-1:0] reach;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      needs_out = busy_ff && ((cmd_ff == CMD_EMIT) || (n_ff > {1'b0, d_ff}));
      out_free  = !rsp_valid_ff || !rsp_stall;
      step      = busy_ff && (!needs_out || out_free);
      job_done  = step && ((cmd_ff == CMD_EMIT) || (d_ff == '0));
      emit      = step && needs_out;
      q_pop     = q_valid && (!busy_ff || job_done);
   end

   always_comb begin
      emit_data = '0;
      lsum  = '0;
      rdiff = '0;
      reach = '0;
      for (int k = 1; k <= SLOTS; k++) begin
         lsum  = {1'b0, cfg.right_size} + SUM_BITS'(k);
         rdiff = {1'b0, cfg.right_size} - SUM_BITS'(k);
         reach = SEEN_BITS'(d_ff) + SEEN_BITS'(k);
         if (SIZE_BITS'(k) <= cfg.left_size) begin
            if (n_ff > reach) begin
               emit_data.left[k-1] = ID_FIELD_BITS'(window_ff[lsum[WIN_IDX_BITS-1:0]]);
            end else begin
               emit_data.left[k-1] = cfg.start_pad;
            end
         end
         if (SIZE_BITS'(k) <= cfg.right_size) begin
            if (SIZE_BITS'(k) <= d_ff) begin
               emit_data.right[k-1] = ID_FIELD_BITS'(window_ff[rdiff[WIN_IDX_BITS-1:0]]);
            end else begin
               emit_data.right[k-1] = cfg.end_pad;
            end
         end
      end
      emit_data.final_position = (cmd_ff == CMD_FLUSH) && (d_ff == '0);
      emit_data.run_last       = (cmd_ff == CMD_EMIT) || (d_ff == '0);
   end

   always_comb begin
      busy_in = busy_ff;
      cmd_in  = cmd_ff;
      d_in    = d_ff;
      n_in    = n_ff;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         window_in[i] = window_ff[i];
      end
      if (job_done) begin
         busy_in = 1'b0;
      end
      if (step && !job_done) begin
         d_in = d_ff - 1'b1;
         for (int i = 1; i < WIN_DEPTH; i++) begin
            window_in[i] = window_ff[i-1];
         end
      end
      if (q_pop) begin
         busy_in = (q_entry.cmd != CMD_SHIFT);
         cmd_in  = q_entry.cmd;
         d_in    = cfg.right_size;
         n_in    = q_entry.seen;
         window_in[0] = q_entry.word[WORD_BITS-1:0];
         for (int i = 1; i < WIN_DEPTH; i++) begin
            window_in[i] = window_ff[i-1];
         end
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      d_ff        <= d_in;
      n_ff        <= n_in;
      rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         window_ff[i] <= window_in[i];
      end
   end

endmodule

>>> design/token_context_window_top.sv
// Context window over a stream of word ids, one word per req_ item.
// req_sentence_end marks the last word of a sentence. For every sentence
// position the block returns up to four ids on each side; positions before
// the start read start_pad_id, positions past the end read end_pad_id, and
// slots beyond left_size or right_size read 0.
// req_ and rsp_ use valid/stall: a word moves on a clock edge with valid
// high and stall low. csr_ writes take effect at once (csr_ready is always
// high) and must only be issued while the block is idle.
// The block takes one word per cycle while req_stall is low. A sentence's
// last word holds the back end while it walks the trailing positions, one
// per cycle unless rsp_stall holds a result, padding ones included. From
// accept, a word passes the queue, pop with window shift, result register.
// When rsp_stall is high the result register holds and the back end waits;
// the queue keeps taking words until it fills, then req_stall rises.
// Reset clears the sentence counter, the queue, the pending job and
// rsp_valid, and loads the default register values.
module token_context_window_top import tcw_pkg::*; #(
   parameter int MAX_LEFT  = DEFAULT_MAX_LEFT,
   parameter int MAX_RIGHT = DEFAULT_MAX_RIGHT,
   parameter int ID_BITS   = DEFAULT_ID_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [ID_FIELD_BITS-1:0]  req_word_id,
   input  logic                      req_sentence_end,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [ID_FIELD_BITS-1:0]  rsp_left_one,
   output logic [ID_FIELD_BITS-1:0]  rsp_left_two,
   output logic [ID_FIELD_BITS-1:0]  rsp_left_three,
   output logic [ID_FIELD_BITS-1:0]  rsp_left_four,
   output logic [ID_FIELD_BITS-1:0]  rsp_right_one,
   output logic [ID_FIELD_BITS-1:0]  rsp_right_two,
   output logic [ID_FIELD_BITS-1:0]  rsp_right_three,
   output logic [ID_FIELD_BITS-1:0]  rsp_right_four,
   output logic                      rsp_final_position,
   output logic                      rsp_run_last,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int CAP_LEFT  = (MAX_LEFT < SLOTS) ? MAX_LEFT : SLOTS;
   localparam int CAP_RIGHT = (MAX_RIGHT < SLOTS) ? MAX_RIGHT : SLOTS;
   localparam int WIN_DEPTH = CAP_LEFT + CAP_RIGHT + 1;
   localparam int WORD_BITS = (ID_BITS < ID_FIELD_BITS) ? ID_BITS : ID_FIELD_BITS;
   localparam logic [SIZE_BITS-1:0] LEFT_CAP  = SIZE_BITS'(CAP_LEFT);
   localparam logic [SIZE_BITS-1:0] RIGHT_CAP = SIZE_BITS'(CAP_RIGHT);

   logic [SIZE_BITS-1:0]     left_size_ff;
   logic [SIZE_BITS-1:0]     left_size_in;
   logic [SIZE_BITS-1:0]     right_size_ff;
   logic [SIZE_BITS-1:0]     right_size_in;
   logic [ID_FIELD_BITS-1:0] start_pad_ff;
   logic [ID_FIELD_BITS-1:0] start_pad_in;
   logic [ID_FIELD_BITS-1:0] end_pad_ff;
   logic [ID_FIELD_BITS-1:0] end_pad_in;

   cfg_type   cfg;
   logic      q_push;
   logic      q_full;
   logic      q_valid;
   logic      q_pop;
   entry_type q_push_entry;
   entry_type q_pop_entry;
   rsp_type   rsp_data;

   assign csr_ready = 1'b1;

   always_comb begin
      left_size_in  = left_size_ff;
      right_size_in = right_size_ff;
      start_pad_in  = start_pad_ff;
      end_pad_in    = end_pad_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_LEFT_SIZE:  left_size_in  = csr_wdata[SIZE_BITS-1:0];
            CSR_RIGHT_SIZE: right_size_in = csr_wdata[SIZE_BITS-1:0];
            CSR_START_PAD:  start_pad_in  = csr_wdata;
            CSR_END_PAD:    end_pad_in    = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_size_ff  <= LEFT_SIZE_RESET;
         right_size_ff <= RIGHT_SIZE_RESET;
         start_pad_ff  <= START_PAD_RESET;
         end_pad_ff    <= END_PAD_RESET;
      end else begin
         left_size_ff  <= left_size_in;
         right_size_ff <= right_size_in;
         start_pad_ff  <= start_pad_in;
         end_pad_ff    <= end_pad_in;
      end
   end

   always_comb begin
      cfg.left_size  = (left_size_ff > LEFT_CAP) ? LEFT_CAP : left_size_ff;
      cfg.right_size = (right_size_ff > RIGHT_CAP) ? RIGHT_CAP : right_size_ff;
      cfg.start_pad  = ID_FIELD_BITS'(start_pad_ff[WORD_BITS-1:0]);
      cfg.end_pad    = ID_FIELD_BITS'(end_pad_ff[WORD_BITS-1:0]);
   end

   tcw_front #(
      .WORD_BITS (WORD_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word_id      (req_word_id),
      .req_sentence_end (req_sentence_end),
      .cfg              (cfg),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (q_push_entry)
   );

   tcw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .valid      (q_valid),
      .pop        (q_pop),
      .pop_entry  (q_pop_entry)
   );

   tcw_back #(
      .WIN_DEPTH (WIN_DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_entry   (q_pop_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_left_one       = rsp_data.left[0];
   assign rsp_left_two       = rsp_data.left[1];
   assign rsp_left_three     = rsp_data.left[2];
   assign rsp_left_four      = rsp_data.left[3];
   assign rsp_right_one      = rsp_data.right[0];
   assign rsp_right_two      = rsp_data.right[1];
   assign rsp_right_three    = rsp_data.right[2];
   assign rsp_right_four     = rsp_data.right[3];
   assign rsp_final_position = rsp_data.final_position;
   assign rsp_run_last       = rsp_data.run_last;

   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("queue written while full");

   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("queue read while empty");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_final_position) |-> rsp_run_last)
      else $error("last position of a sentence not marked as last result");

   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

>>> test/token_context_window_top_test.sv
module token_context_window_top_test;
   import tcw_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW_DEPTH = DEFAULT_MAX_LEFT + DEFAULT_MAX_RIGHT + 1;

   class window_scoreboard;
      logic [ID_FIELD_BITS-1:0] history [WINDOW_DEPTH];
      int unsigned              seen;
      logic [SIZE_BITS-1:0]     left_size;
      logic [SIZE_BITS-1:0]     right_size;
      logic [ID_FIELD_BITS-1:0] start_pad;
      logic [ID_FIELD_BITS-1:0] end_pad;
      rsp_type                  expected_positions [$];
      int                       errors;
      int                       words;
      int                       sentences;
      int                       results;

      function new();
         foreach (history[i]) history[i] = '0;
         seen       = 0;
         left_size  = LEFT_SIZE_RESET;
         right_size = RIGHT_SIZE_RESET;
         start_pad  = START_PAD_RESET;
         end_pad    = END_PAD_RESET;
         errors     = 0;
         words      = 0;
         sentences  = 0;
         results    = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_LEFT_SIZE:  left_size  = data[SIZE_BITS-1:0];
            CSR_RIGHT_SIZE: right_size = data[SIZE_BITS-1:0];
            CSR_START_PAD:  start_pad  = data[ID_FIELD_BITS-1:0];
            CSR_END_PAD:    end_pad    = data[ID_FIELD_BITS-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned clamp_size(logic [SIZE_BITS-1:0] v, int unsigned cap);
         int unsigned c;
         c = (cap < SLOTS) ? cap : SLOTS;
         return (v > c) ? c : int'(v);
      endfunction

      function rsp_type position(int unsigned d, int unsigned n, int unsigned ls,
                                 int unsigned rs, bit at_end, bit last_of_run);
         rsp_type r;
         r = '0;
         for (int unsigned k = 1; k <= SLOTS; k++) begin
            if (k <= ls)
               r.left[k-1] = (n > d + k && d + k < WINDOW_DEPTH) ? history[d+k] : start_pad;
            if (k <= rs)
               r.right[k-1] = (k <= d) ? history[d-k] : end_pad;
         end
         r.final_position = at_end && d == 0;
         r.run_last       = last_of_run;
         return r;
      endfunction

      function void note_word(logic [ID_FIELD_BITS-1:0] w, logic at_end);
         int unsigned ls;
         int unsigned rs;
         int unsigned n;
         int unsigned d;
         ls = clamp_size(left_size, DEFAULT_MAX_LEFT);
         rs = clamp_size(right_size, DEFAULT_MAX_RIGHT);
         for (int i = WINDOW_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
         history[0] = w;
         if (seen < SEEN_MAX) seen++;
         n = seen;
         words++;
         if (!at_end) begin
            if (n > rs) expected_positions.push_back(position(rs, n, ls, rs, 1'b0, 1'b1));
         end else begin
            d = (n - 1 < rs) ? n - 1 : rs;
            forever begin
               expected_positions.push_back(position(d, n, ls, rs, 1'b1, d == 0));
               if (d == 0) break;
               d--;
            end
            seen = 0;
            sentences++;
         end
      endfunction

      function void compare(string name, logic [ID_FIELD_BITS-1:0] exp_v,
                            logic [ID_FIELD_BITS-1:0] got_v);
         if (exp_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp_r;
         string   left_names [SLOTS];
         string   right_names [SLOTS];
         left_names  = '{"left_one", "left_two", "left_three", "left_four"};
         right_names = '{"right_one", "right_two", "right_three", "right_four"};
         if (expected_positions.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
            return;
         end
         exp_r = expected_positions.pop_front();
         results++;
         for (int k = 0; k < SLOTS; k++) begin
            compare(left_names[k], exp_r.left[k], got.left[k]);
            compare(right_names[k], exp_r.right[k], got.right[k]);
         end
         compare("final_position", 16'(exp_r.final_position), 16'(got.final_position));
         compare("run_last", 16'(exp_r.run_last), 16'(got.run_last));
      endfunction

      function void check_leftover();
         if (expected_positions.size() != 0) begin
            $error("%0d expected result words never arrived", expected_positions.size());
            errors++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset            = 1'b1;
   logic                      req_valid        = 1'b0;
   logic                      req_stall;
   logic [ID_FIELD_BITS-1:0]  req_word_id      = '0;
   logic                      req_sentence_end = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall        = 1'b0;
   logic [ID_FIELD_BITS-1:0]  rsp_left_one;
   logic [ID_FIELD_BITS-1:0]  rsp_left_two;
   logic [ID_FIELD_BITS-1:0]  rsp_left_three;
   logic [ID_FIELD_BITS-1:0]  rsp_left_four;
   logic [ID_FIELD_BITS-1:0]  rsp_right_one;
   logic [ID_FIELD_BITS-1:0]  rsp_right_two;
   logic [ID_FIELD_BITS-1:0]  rsp_right_three;
   logic [ID_FIELD_BITS-1:0]  rsp_right_four;
   logic                      rsp_final_position;
   logic                      rsp_run_last;
   logic                      csr_valid        = 1'b0;
   logic                      csr_ready;
   csr_index_type             csr_index        = CSR_LEFT_SIZE;
   logic [CSR_DATA_BITS-1:0]  csr_wdata        = '0;

   window_scoreboard sb;
   int unsigned      send_idle_pct  = 0;
   int unsigned      recv_stall_pct = 0;
   int unsigned      words_to_go    = 0;
   int               csr_writes     = 0;

   token_context_window_top DUT (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.left  = {rsp_left_four, rsp_left_three, rsp_left_two, rsp_left_one};
         got.right = {rsp_right_four, rsp_right_three, rsp_right_two, rsp_right_one};
         got.final_position = rsp_final_position;
         got.run_last       = rsp_run_last;
         sb.check_result(got);
      end
   end

   task automatic send_word(logic [ID_FIELD_BITS-1:0] w, logic at_end);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_word_id      <= w;
      req_sentence_end <= at_end;
      do @(posedge clock); while (req_stall);
      sb.note_word(w, at_end);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_positions.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      csr_writes++;
   endtask

   task automatic reconfigure(logic [CSR_DATA_BITS-1:0] ls, logic [CSR_DATA_BITS-1:0] rs,
                              logic [CSR_DATA_BITS-1:0] sp, logic [CSR_DATA_BITS-1:0] ep);
      drain();
      write_csr(CSR_LEFT_SIZE, ls);
      write_csr(CSR_RIGHT_SIZE, rs);
      write_csr(CSR_START_PAD, sp);
      write_csr(CSR_END_PAD, ep);
      csr_valid <= 1'b0;
   endtask

   task automatic send_sentence_word();
      logic [ID_FIELD_BITS-1:0] w;
      if (words_to_go == 0)
         words_to_go = ($urandom_range(7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      case ($urandom_range(9))
         0: w = '0;
         1: w = '1;
         default: w = ID_FIELD_BITS'($urandom);
      endcase
      send_word(w, words_to_go == 1);
      words_to_go--;
   endtask

   function automatic logic [CSR_DATA_BITS-1:0] random_pad();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         default: return CSR_DATA_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] random_size();
      return {13'($urandom), 3'($urandom_range(7))};
   endfunction

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(16'h0000, 1'b1);
      send_word(16'hFFFF, 1'b0);
      send_word(16'h0000, 1'b1);

      reconfigure(16'd4, 16'd4, 16'hFFFF, 16'h0000);
      send_word(16'hFFFF, 1'b0);
      send_word(16'h0000, 1'b0);
      send_word(16'h1234, 1'b0);
      send_word(16'hFFFF, 1'b0);
      send_word(16'h5A5A, 1'b0);
      send_word(16'hA5A5, 1'b1);

      reconfigure(16'd0, 16'd0, 16'h0000, 16'hFFFF);
      send_word(16'h0001, 1'b0);
      send_word(16'h8000, 1'b1);

      reconfigure(16'hFFFF, 16'hFFFD, 16'h5555, 16'hAAAA);
      for (int i = 0; i < 4; i++) send_word(ID_FIELD_BITS'($urandom), i == 3);

      // change sizes while a sentence is open
      reconfigure(16'd2, 16'd2, 16'h0001, 16'h0002);
      for (int i = 0; i < 3; i++) send_word(ID_FIELD_BITS'($urandom), 1'b0);
      reconfigure(16'd4, 16'd0, 16'h0003, 16'h0004);
      send_word(ID_FIELD_BITS'($urandom), 1'b0);
      reconfigure(16'd1, 16'd4, 16'h0005, 16'h0006);
      send_word(ID_FIELD_BITS'($urandom), 1'b1);

      for (int phase = 0; phase < 8; phase++) begin
         reconfigure(random_size(), random_size(), random_pad(), random_pad());
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         repeat (37) send_sentence_word();
      end
      while (words_to_go != 0) send_sentence_word();

      drain();
      sb.check_leftover();
      $display("covered %0d words in %0d sentences, %0d result words, %0d register writes",
               sb.words, sb.sentences, sb.results, csr_writes);
      $display("idle modes: none, sender gaps, receiver stalls, both; sizes 0 to 7");
      if (sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
